// File: rtl/cpc_pkg.sv
// shared types, constants and power-of-ten table for the circular prime checker
package cpc_pkg;

	localparam int CNT_W = 4;
	localparam int POW_W = 34;
	localparam int NUM_W = 31;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COUNT,
		S_TEST,
		S_TRIAL,
		S_TDIV,
		S_ROT,
		S_RCNT,
		S_RDIV,
		S_FINISH
	} cpc_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cpc_div_stat_t;

	function automatic logic [POW_W-1:0] pow10(input logic [CNT_W-1:0] k);
		logic [POW_W-1:0] p;
		case (k)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			4'd10:   p = 34'd10000000000;
			default: p = {POW_W{1'b1}};
		endcase
		return p;
	endfunction

endpackage

// File: rtl/cpc_div.sv
// shared restoring divider, one quotient bit per cycle
module cpc_div
	import cpc_pkg::*;
#(
	parameter int W = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	output cpc_div_stat_t stat,
	output logic [W-1:0]  quotient,
	output logic [W-1:0]  remainder
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          ge;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: rtl/circular_prime_check.sv
// top level of the circular prime checker: sequencer and datapath around one divider
//
// Input channel: number with in_valid/in_stall; a transfer happens when in_valid is
// high and in_stall is low. Output channel: is_circular and out_of_range with
// out_valid/out_stall, one result per input item.
// The block works on one number at a time and holds in_stall high from the transfer
// until the result has been moved into the output register. A new number can be
// taken while that result still waits for the receiver.
// Sequence: the digits are counted first, then per rotation a digit count and one
// divide by ten, and per trial divisor one divider pass of VW quotient bits (VW is
// 30 at the default MAX_DIGITS). The worst case is nine rotations with some 15800
// odd divisors each; numbers below two or with too many digits finish without any
// divider pass.
// The shared restoring divider, one quotient bit per cycle, sets the pace.
// When the receiver stalls, the result stays on the outputs and the next result
// waits in the sequencer until the output register is free.
// Reset clears the sequencer and the output valid; no memories need clearing.
module circular_prime_check
	import cpc_pkg::*;
#(
	parameter int MAX_DIGITS = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [NUM_W-1:0] number,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             is_circular,
	output logic             out_of_range
);

	localparam int VW = $clog2(pow10(CNT_W'(MAX_DIGITS)));
	localparam int DW = VW / 2 + 2;
	localparam int SW = VW + 2;

	cpc_state_t    state_q;
	cpc_state_t    state_d;
	cpc_div_stat_t div_st;

	logic [NUM_W-1:0] n_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] left_q;
	logic [VW-1:0]    cur_q;
	logic [DW-1:0]    d_q;
	logic [SW-1:0]    sq_q;
	logic             res_circ_q;
	logic             res_oor_q;
	logic             out_valid_q;
	logic             circ_q;
	logic             oor_q;

	logic          div_start;
	logic [VW-1:0] div_divisor;
	logic [VW-1:0] div_quo;
	logic [VW-1:0] div_rem;
	logic          n_ge;
	logic          cur_ge;
	logic          n_lt2;
	logic          too_long;
	logic          sq_gt;
	logic          out_free;
	logic [VW-1:0] scale;
	logic [VW-1:0] rot_val;

	assign n_ge     = POW_W'(n_q) >= pow10(cnt_q);
	assign cur_ge   = POW_W'(cur_q) >= pow10(cnt_q);
	assign n_lt2    = n_q < NUM_W'(2);
	assign too_long = cnt_q > CNT_W'(MAX_DIGITS);
	assign sq_gt    = sq_q > SW'(cur_q);
	assign out_free = ~out_valid_q | ~out_stall;
	assign scale    = VW'(pow10(cnt_q - CNT_W'(1)));
	assign rot_val  = VW'(VW'(div_rem[3:0]) * scale + div_quo);

	cpc_div #(
		.W(VW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (cur_q),
		.divisor   (div_divisor),
		.stat      (div_st),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_COUNT;
			end
			S_COUNT: begin
				if (!n_ge) begin
					if (n_lt2 || too_long) state_d = S_FINISH;
					else                   state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (cur_q < VW'(2))      state_d = S_FINISH;
				else if (cur_q == VW'(2)) state_d = S_ROT;
				else if (!cur_q[0])      state_d = S_FINISH;
				else                     state_d = S_TRIAL;
			end
			S_TRIAL: begin
				state_d = sq_gt ? S_ROT : S_TDIV;
			end
			S_TDIV: begin
				if (div_st.done) state_d = (div_rem == '0) ? S_FINISH : S_TRIAL;
			end
			S_ROT: begin
				if (left_q == CNT_W'(1))      state_d = S_FINISH;
				else if (cur_q < VW'(10))     state_d = S_TEST;
				else                          state_d = S_RCNT;
			end
			S_RCNT: begin
				if (!cur_ge) state_d = S_RDIV;
			end
			S_RDIV: begin
				if (div_st.done) state_d = S_TEST;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall    = 1'b1;
		div_start   = 1'b0;
		div_divisor = VW'(d_q);
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_TRIAL: begin
				div_start = ~sq_gt;
			end
			S_RCNT: begin
				div_start   = ~cur_ge;
				div_divisor = VW'(10);
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH && out_free) out_valid_q <= 1'b1;
			else if (!out_stall)                 out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= number;
				cnt_q <= CNT_W'(1);
			end
			S_COUNT: begin
				if (n_ge) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					cur_q      <= VW'(n_q);
					left_q     <= cnt_q;
					res_circ_q <= 1'b0;
					res_oor_q  <= ~n_lt2 & too_long;
				end
			end
			S_TEST: begin
				d_q  <= DW'(3);
				sq_q <= SW'(9);
			end
			S_TDIV: begin
				if (div_st.done) begin
					d_q  <= d_q + DW'(2);
					sq_q <= sq_q + (SW'(d_q) << 2) + SW'(4);
				end
			end
			S_ROT: begin
				left_q <= left_q - CNT_W'(1);
				cnt_q  <= CNT_W'(1);
				if (left_q == CNT_W'(1)) res_circ_q <= 1'b1;
			end
			S_RCNT: begin
				if (cur_ge) cnt_q <= cnt_q + CNT_W'(1);
			end
			S_RDIV: begin
				if (div_st.done) cur_q <= rot_val;
			end
			S_FINISH: begin
				if (out_free) begin
					circ_q <= res_circ_q;
					oor_q  <= res_oor_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign is_circular  = circ_q;
	assign out_of_range = oor_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_circular && out_of_range))
		else $error("result marks both circular and out of range");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_COUNT))
		else $error("transfer in did not start digit count");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && state_q != S_FINISH) |=> !out_valid)
		else $error("result repeated after output transfer");

endmodule

// File: test/cpc_checker.sv
// checker for the circular prime block: predicts each verdict and compares the results
module cpc_checker
	import cpc_pkg::*;
#(
	parameter int MAX_DIGITS = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [NUM_W-1:0] number,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic             is_circular,
	input  logic             out_of_range,
	output int               mismatches,
	output int               outstanding,
	output int               n_done,
	output int               n_circ,
	output int               n_oor
);

	typedef struct packed {
		logic [NUM_W-1:0] value;
		logic             circular;
		logic             too_long;
	} verdict_t;

	verdict_t verdict_q[$];
	verdict_t want;
	int       bad;

	function automatic int unsigned decimal_len(input longint unsigned v);
		int unsigned c;
		c = 1;
		while (v >= 10) begin
			v = v / 10;
			c++;
		end
		return c;
	endfunction

	function automatic longint unsigned rotate_digit(input longint unsigned v);
		longint unsigned scale;
		int unsigned     len;
		if (v < 10)
			return v;
		scale = 1;
		len = decimal_len(v);
		for (int unsigned k = 1; k < len; k++)
			scale = scale * 10;
		return (v % 10) * scale + v / 10;
	endfunction

	function automatic bit trial_prime(input longint unsigned v);
		longint unsigned d;
		if (v < 2)
			return 1'b0;
		if (v == 2)
			return 1'b1;
		if (v[0] == 1'b0)
			return 1'b0;
		for (d = 3; d * d <= v; d += 2) begin
			if (v % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic verdict_t circular_verdict(input logic [NUM_W-1:0] n);
		verdict_t        r;
		longint unsigned cur;
		int unsigned     len;
		r.value = n;
		r.circular = 1'b0;
		r.too_long = 1'b0;
		if (n < 2)
			return r;
		len = decimal_len(n);
		if (len > MAX_DIGITS) begin
			r.too_long = 1'b1;
			return r;
		end
		cur = n;
		r.circular = 1'b1;
		for (int unsigned i = 0; i < len; i++) begin
			if (!trial_prime(cur)) begin
				r.circular = 1'b0;
				break;
			end
			cur = rotate_digit(cur);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q.delete();
			mismatches <= 0;
			outstanding <= 0;
			n_done <= 0;
			n_circ <= 0;
			n_oor <= 0;
		end else begin
			bad = 0;
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("result transfer with no number pending: is_circular %0b, out_of_range %0b",
						is_circular, out_of_range);
					bad++;
				end else begin
					want = verdict_q.pop_front();
					if (is_circular !== want.circular) begin
						$error("is_circular mismatch for number %0d: expected %0b, actual %0b",
							want.value, want.circular, is_circular);
						bad++;
					end
					if (out_of_range !== want.too_long) begin
						$error("out_of_range mismatch for number %0d: expected %0b, actual %0b",
							want.value, want.too_long, out_of_range);
						bad++;
					end
					n_done <= n_done + 1;
					n_circ <= n_circ + int'(want.circular);
					n_oor <= n_oor + int'(want.too_long);
				end
			end
			if (in_valid && !in_stall)
				verdict_q.push_back(circular_verdict(number));
			mismatches <= mismatches + bad;
			outstanding <= verdict_q.size();
		end
	end

endmodule

// File: test/tb_circular_prime_check.sv
// testbench top for the circular prime block: reset, stimulus, pacing and verdict
module tb_circular_prime_check;
	import cpc_pkg::*;

	localparam int MAX_DIGITS = 9;
	localparam int CYCLE_LIMIT = 8_000_000;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int N_CIRC_PRIMES = 43;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [NUM_W-1:0] number;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             is_circular;
	logic             out_of_range;

	int unsigned gap_pct;
	int unsigned stall_pct;
	int          mismatches;
	int          outstanding;
	int          n_done;
	int          n_circ;
	int          n_oor;

	circular_prime_check #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.number(number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_circular(is_circular),
		.out_of_range(out_of_range)
	);

	cpc_checker #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.number(number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_circular(is_circular),
		.out_of_range(out_of_range),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.n_done(n_done),
		.n_circ(n_circ),
		.n_oor(n_oor)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// circular primes of up to five digits
	function automatic int unsigned circ_prime(input int unsigned idx);
		case (idx)
			0:  return 2;
			1:  return 3;
			2:  return 5;
			3:  return 7;
			4:  return 11;
			5:  return 13;
			6:  return 17;
			7:  return 31;
			8:  return 37;
			9:  return 71;
			10: return 73;
			11: return 79;
			12: return 97;
			13: return 113;
			14: return 131;
			15: return 197;
			16: return 199;
			17: return 311;
			18: return 337;
			19: return 373;
			20: return 719;
			21: return 733;
			22: return 919;
			23: return 971;
			24: return 991;
			25: return 1193;
			26: return 1931;
			27: return 3119;
			28: return 3779;
			29: return 7793;
			30: return 7937;
			31: return 9311;
			32: return 9377;
			33: return 11939;
			34: return 19391;
			35: return 19937;
			36: return 37199;
			37: return 39119;
			38: return 71993;
			39: return 91193;
			40: return 93719;
			41: return 93911;
			default: return 99371;
		endcase
	endfunction

	// large values are kept cheap: too long, even, or a multiple of three
	function automatic logic [NUM_W-1:0] random_number();
		int unsigned v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom_range(999);
			4, 5:       v = circ_prime($urandom_range(N_CIRC_PRIMES - 1));
			6:          v = $urandom_range(99999, 1000) | 32'd1;
			7:          v = $urandom_range(32'h7FFF_FFFF, 1_000_000_000);
			8: begin
				v = $urandom & 32'h7FFF_FFFF;
				if (v < 1_000_000_000)
					v = v & ~32'd1;
			end
			default: begin
				v = $urandom_range(999_999_999, 100_000_000);
				v = v - v % 3;
			end
		endcase
		return v[NUM_W-1:0];
	endfunction

	task automatic send_number(input logic [NUM_W-1:0] n);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		number <= n;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		number = '0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_number(31'd0);
		send_number(31'd1);
		send_number(31'd2);
		send_number(31'd3);
		send_number(31'd4);
		send_number(31'd9);
		send_number(31'd49);
		send_number(31'd121);
		send_number(31'd19);
		send_number(31'd23);
		send_number(31'd101);
		send_number(31'd113);
		send_number(31'd197);
		send_number(31'd1009);
		send_number(31'd1193);
		send_number(31'd99371);
		send_number(31'd999331);
		send_number(31'd999999998);
		send_number(31'd999999999);
		send_number(31'd536870912);
		send_number(31'd1000000000);
		send_number(31'd1073741824);
		send_number(31'h7FFF_FFFF);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 50; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 50; end
				default: begin gap_pct = 15; stall_pct = 15; end
			endcase
			repeat (ITEMS_PER_PHASE) send_number(random_number());
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("checked %0d numbers under four pacing mixes: %0d circular, %0d too long",
			n_done, n_circ, n_oor);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
